>>> sv/tga_rle_pkg.sv
// Shared types and constants for the TGA run-length pixel decoder.
`default_nettype none
package tga_rle_pkg;

    localparam int CFG_W       = 13;
    localparam int CFG_IDX_W   = 2;
    localparam int MAX_DIM_DEF = 4096;
    localparam int BYTE_W      = 8;
    localparam int CNT_W       = 8;
    localparam int POS_OUT_W   = 12;

    localparam logic [BYTE_W-1:0] HDR_LEN_MASK = 8'h7F;
    localparam int                HDR_RUN_BIT  = 7;
    localparam logic [2:0]        BPP_RGB      = 3'd3;
    localparam logic [2:0]        BPP_RGBA     = 3'd4;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RLE_MODE = 2'd0,
        CFG_BPP      = 2'd1,
        CFG_WIDTH    = 2'd2,
        CFG_HEIGHT   = 2'd3
    } t_cfg_reg;

    typedef struct packed {
        logic              place;
        logic [CNT_W-1:0]  cnt;
    } t_place_req;

    typedef struct packed {
        logic [BYTE_W-1:0] red;
        logic [BYTE_W-1:0] green;
        logic [BYTE_W-1:0] blue;
        logic [BYTE_W-1:0] alpha;
    } t_pixel;

    typedef struct packed {
        logic                 emit;
        logic [POS_OUT_W-1:0] column;
        logic [POS_OUT_W-1:0] row;
        logic [CNT_W-1:0]     cnt;
        logic                 last;
    } t_pos_res;

endpackage
`default_nettype wire

>>> sv/tga_rle_pkt.sv
// Packet header parsing and pixel byte assembly with BGR(A) to RGB(A) swap.
`default_nettype none
module tga_rle_pkt (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_step,
    input  wire logic                          i_first,
    input  wire logic [tga_rle_pkg::BYTE_W-1:0] i_data_byte,
    input  wire logic                          i_rle_mode,
    input  wire logic                          i_bpp4,
    input  wire logic                          i_finished,
    output tga_rle_pkg::t_place_req            o_req,
    output tga_rle_pkg::t_pixel                o_pixel
);

    logic                                   r_expect_hdr, n_expect_hdr;
    logic                                   r_is_run, n_is_run;
    logic [tga_rle_pkg::CNT_W-1:0]          r_left, n_left;
    logic [1:0]                             r_byte_idx, n_byte_idx;
    logic [3:0][tga_rle_pkg::BYTE_W-1:0]    r_pix, n_pix;

    logic                                   c_expect_hdr;
    logic                                   c_is_run;
    logic [tga_rle_pkg::CNT_W-1:0]          c_left;
    logic [1:0]                             c_byte_idx;
    logic [3:0][tga_rle_pkg::BYTE_W-1:0]    c_pix;
    logic [2:0]                             bpp;

    always_comb begin
        // A first byte restarts packet state before the byte is handled.
        c_expect_hdr = r_expect_hdr;
        c_is_run     = r_is_run;
        c_left       = r_left;
        c_byte_idx   = r_byte_idx;
        if (i_first) begin
            c_expect_hdr = 1'b1;
            c_is_run     = 1'b0;
            c_left       = '0;
            c_byte_idx   = '0;
        end
        bpp = i_bpp4 ? tga_rle_pkg::BPP_RGBA : tga_rle_pkg::BPP_RGB;

        n_expect_hdr = c_expect_hdr;
        n_is_run     = c_is_run;
        n_left       = c_left;
        n_byte_idx   = c_byte_idx;
        c_pix        = r_pix;
        n_pix        = r_pix;
        o_req.place  = 1'b0;
        o_req.cnt    = tga_rle_pkg::CNT_W'(1);

        if (!(i_finished && !i_first)) begin
            if (i_rle_mode && c_expect_hdr) begin
                n_is_run     = i_data_byte[tga_rle_pkg::HDR_RUN_BIT];
                n_left       = (i_data_byte & tga_rle_pkg::HDR_LEN_MASK)
                               + tga_rle_pkg::CNT_W'(1);
                n_expect_hdr = 1'b0;
                n_byte_idx   = '0;
            end else begin
                c_pix[c_byte_idx] = i_data_byte;
                n_pix             = c_pix;
                if (({1'b0, c_byte_idx} + 3'd1) < bpp) begin
                    n_byte_idx = c_byte_idx + 2'd1;
                end else begin
                    n_byte_idx  = '0;
                    o_req.place = 1'b1;
                    if (i_rle_mode && c_is_run) begin
                        o_req.cnt    = c_left;
                        n_left       = '0;
                        n_expect_hdr = 1'b1;
                    end else if (i_rle_mode) begin
                        if (c_left != '0) begin
                            n_left = c_left - tga_rle_pkg::CNT_W'(1);
                        end
                        if (n_left == '0) begin
                            n_expect_hdr = 1'b1;
                        end
                    end
                    if (!i_bpp4) begin
                        n_pix[3] = '0;
                    end
                end
            end
        end

        o_pixel.red   = c_pix[2];
        o_pixel.green = c_pix[1];
        o_pixel.blue  = c_pix[0];
        o_pixel.alpha = i_bpp4 ? c_pix[3] : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expect_hdr <= 1'b1;
            r_is_run     <= 1'b0;
            r_left       <= '0;
            r_byte_idx   <= '0;
            r_pix        <= '0;
        end else if (i_step) begin
            r_expect_hdr <= n_expect_hdr;
            r_is_run     <= n_is_run;
            r_left       <= n_left;
            r_byte_idx   <= n_byte_idx;
            r_pix        <= n_pix;
        end
    end

endmodule
`default_nettype wire

>>> sv/tga_rle_pos.sv
// Pixel position tracking: row wrap, run clipping at the image end, position advance.
`default_nettype none
module tga_rle_pos #(
    parameter int DIM_W = 13
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_step,
    input  wire logic                    i_first,
    input  wire logic [DIM_W-1:0]        i_width,
    input  wire logic [DIM_W-1:0]        i_height,
    input  wire tga_rle_pkg::t_place_req i_req,
    output logic                         o_finished,
    output tga_rle_pkg::t_pos_res        o_res
);

    localparam int REM_W  = 2 * DIM_W;
    localparam int CMP_W  = (REM_W > 9) ? REM_W : 9;
    localparam int DIV_W  = DIM_W + tga_rle_pkg::CNT_W;
    localparam int HALF_Q = tga_rle_pkg::CNT_W / 2;

    logic [DIM_W-1:0]               r_col, n_col;
    logic [DIM_W-1:0]               r_row, n_row;
    logic                           r_fin, n_fin;
    logic                           r_pend, n_pend;
    logic                           r_pend2, n_pend2;
    logic [DIV_W-1:0]               r_div_rem, n_div_rem;
    logic [tga_rle_pkg::CNT_W-1:0]  r_div_q, n_div_q;
    logic [DIM_W-1:0]               r_adv_row, n_adv_row;
    logic [DIM_W-1:0]               r_adv_w, n_adv_w;
    logic [REM_W-1:0]               r_rem, n_rem;

    logic                           wrap;
    logic [DIM_W-1:0]               col_w;
    logic [DIM_W-1:0]               row_w;
    logic [REM_W-1:0]               rem_calc;
    logic [tga_rle_pkg::CNT_W-1:0]  cnt_c;
    logic                           last_c;
    logic [DIV_W-1:0]               div_rem;
    logic [tga_rle_pkg::CNT_W-1:0]  div_q;

    assign wrap  = (r_col >= i_width);
    assign col_w = wrap ? '0 : r_col;
    assign row_w = wrap ? (r_row + DIM_W'(1)) : r_row;

    // Pixels left in the image from the current position. The register is
    // refreshed every idle cycle; after a placed pixel it is decremented by the
    // repeat count and held while the position advance is still settling.
    assign rem_calc = REM_W'(i_height - row_w) * REM_W'(i_width) - REM_W'(col_w);

    assign cnt_c  = (CMP_W'(i_req.cnt) > CMP_W'(r_rem)) ? tga_rle_pkg::CNT_W'(r_rem)
                                                        : i_req.cnt;
    assign last_c = (CMP_W'(cnt_c) == CMP_W'(r_rem));

    // Restoring division of the advanced column by the width. The quotient is
    // at most 128, so eight compare-subtract steps cover it: the upper four while
    // r_pend is set and the lower four while r_pend2 is set, which writes the position.
    // A pixel needs at least three bytes, so the position is ready in time.
    always_comb begin
        logic [DIV_W-1:0] sub;
        div_rem = r_div_rem;
        div_q   = r_div_q;
        for (int k = HALF_Q - 1; k >= 0; k--) begin
            if (r_pend) begin
                sub = DIV_W'(r_adv_w) << (k + HALF_Q);
            end else begin
                sub = DIV_W'(r_adv_w) << k;
            end
            if (div_rem >= sub) begin
                div_rem = div_rem - sub;
                if (r_pend) begin
                    div_q[k + HALF_Q] = 1'b1;
                end else begin
                    div_q[k] = 1'b1;
                end
            end
        end
    end

    always_comb begin
        n_col       = r_col;
        n_row       = r_row;
        n_fin       = r_fin;
        n_pend      = 1'b0;
        n_pend2     = r_pend;
        n_div_rem   = div_rem;
        n_div_q     = div_q;
        n_adv_row   = r_adv_row;
        n_adv_w     = r_adv_w;
        n_rem       = rem_calc;
        o_res.emit   = 1'b0;
        o_res.column = tga_rle_pkg::POS_OUT_W'(col_w);
        o_res.row    = tga_rle_pkg::POS_OUT_W'(i_height - row_w - DIM_W'(1));
        o_res.cnt    = cnt_c;
        o_res.last   = last_c;

        if (r_pend || r_pend2) begin
            n_rem = r_rem;
        end
        if (r_pend2) begin
            n_col = DIM_W'(div_rem);
            n_row = r_adv_row + DIM_W'(div_q);
        end
        if (i_step) begin
            if (i_first) begin
                n_col   = '0;
                n_row   = '0;
                n_fin   = 1'b0;
                n_pend  = 1'b0;
                n_pend2 = 1'b0;
                n_rem   = rem_calc;
            end else if (i_req.place) begin
                if (row_w >= i_height) begin
                    n_fin = 1'b1;
                    n_col = col_w;
                    n_row = row_w;
                end else begin
                    o_res.emit = 1'b1;
                    n_fin      = last_c;
                    n_pend     = 1'b1;
                    n_div_rem  = DIV_W'(col_w) + DIV_W'(cnt_c);
                    n_div_q    = '0;
                    n_adv_row  = row_w;
                    n_adv_w    = i_width;
                    n_rem      = r_rem - REM_W'(cnt_c);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_row   <= '0;
            r_fin   <= 1'b0;
            r_pend  <= 1'b0;
            r_pend2 <= 1'b0;
        end else begin
            r_col   <= n_col;
            r_row   <= n_row;
            r_fin   <= n_fin;
            r_pend  <= n_pend;
            r_pend2 <= n_pend2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_div_rem <= n_div_rem;
        r_div_q   <= n_div_q;
        r_adv_row <= n_adv_row;
        r_adv_w   <= n_adv_w;
        r_rem     <= n_rem;
    end

    assign o_finished = r_fin;

`ifndef SYNTH
    // The position advance must settle before the next pixel can be placed.
    a_no_place_while_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !((r_pend || r_pend2) && i_step && i_req.place))
        else $error("pixel placed while position advance pending");

    a_last_sets_finished: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.emit && o_res.last) |=> r_fin)
        else $error("last result did not mark the image finished");

    a_clip_only_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.emit |-> (o_res.cnt <= i_req.cnt))
        else $error("repeat count grew when clipped");

    a_finished_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fin && !i_step) |=> r_fin)
        else $error("finished cleared without a first byte");
`endif

endmodule
`default_nettype wire

>>> sv/tga_rle_pixel_decoder.sv
// Top level of the TGA run-length pixel decoder: config registers, input and result registers.
//
// Usage: image-data bytes (after header and color map) enter on the input
// channel, one item per byte, with i_first set on the first byte of an image.
// Each completed literal pixel, or each whole run, leaves on the result
// channel as one item with RGB(A), first column, bottom-up row, repeat count
// and a last flag on the item that completes the image. Bytes after the end
// of the image give no result until the next first byte.
// Configuration registers (mode, pixel size, width, height) are written on
// the config channel, which is always ready; the user must write them only
// while no item is in flight; the block does not enforce it. Data passes the
// input register and then the result register. Throughput: one byte per
// cycle while the receiver is ready, set by the single decode stage between
// the two registers. A stalled receiver holds the result register; the input
// register then fills and ready drops after one more byte.
// Reset clears packet and position state and loads mode 0, 3 bytes per
// pixel, width 1 and height 1.
`default_nettype none
module tga_rle_pixel_decoder #(
    parameter int MAX_DIM = tga_rle_pkg::MAX_DIM_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_in_valid,
    output logic                                    o_in_ready,
    input  wire logic [tga_rle_pkg::BYTE_W-1:0]     i_data_byte,
    input  wire logic                               i_first,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_ready,
    output logic [tga_rle_pkg::BYTE_W-1:0]          o_red,
    output logic [tga_rle_pkg::BYTE_W-1:0]          o_green,
    output logic [tga_rle_pkg::BYTE_W-1:0]          o_blue,
    output logic [tga_rle_pkg::BYTE_W-1:0]          o_alpha,
    output logic [tga_rle_pkg::POS_OUT_W-1:0]       o_column,
    output logic [tga_rle_pkg::POS_OUT_W-1:0]       o_row,
    output logic [tga_rle_pkg::CNT_W-1:0]           o_repeat_count,
    output logic                                    o_last,
    input  wire logic                               i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  wire logic [tga_rle_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [tga_rle_pkg::CFG_W-1:0]      i_cfg_data
);

    localparam int DIM_W = $clog2(MAX_DIM + 1);

    logic                               r_rle_mode;
    logic [2:0]                         r_bpp;
    logic [tga_rle_pkg::CFG_W-1:0]      r_width;
    logic [tga_rle_pkg::CFG_W-1:0]      r_height;

    logic                               r_in_valid;
    logic [tga_rle_pkg::BYTE_W-1:0]     r_in_byte;
    logic                               r_in_first;

    logic                               r_out_valid;
    tga_rle_pkg::t_pixel                r_out_pix;
    tga_rle_pkg::t_pos_res              r_out_res;

    logic                               advance;
    logic                               step;
    logic                               bpp4;
    logic                               finished;
    logic [DIM_W-1:0]                   width;
    logic [DIM_W-1:0]                   height;
    tga_rle_pkg::t_place_req            req;
    tga_rle_pkg::t_pixel                pixel;
    tga_rle_pkg::t_pos_res              res;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rle_mode <= 1'b0;
            r_bpp      <= tga_rle_pkg::BPP_RGB;
            r_width    <= tga_rle_pkg::CFG_W'(1);
            r_height   <= tga_rle_pkg::CFG_W'(1);
        end else if (i_cfg_valid) begin
            unique case (tga_rle_pkg::t_cfg_reg'(i_cfg_index))
                tga_rle_pkg::CFG_RLE_MODE: r_rle_mode <= i_cfg_data[0];
                tga_rle_pkg::CFG_BPP:      r_bpp      <= i_cfg_data[2:0];
                tga_rle_pkg::CFG_WIDTH:    r_width    <= i_cfg_data;
                tga_rle_pkg::CFG_HEIGHT:   r_height   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Zero acts as one and anything above the limit acts as the limit.
    always_comb begin
        if (r_width == '0) begin
            width = DIM_W'(1);
        end else if (32'(r_width) > 32'(MAX_DIM)) begin
            width = DIM_W'(MAX_DIM);
        end else begin
            width = DIM_W'(r_width);
        end
        if (r_height == '0) begin
            height = DIM_W'(1);
        end else if (32'(r_height) > 32'(MAX_DIM)) begin
            height = DIM_W'(MAX_DIM);
        end else begin
            height = DIM_W'(r_height);
        end
    end

    assign bpp4       = (r_bpp >= tga_rle_pkg::BPP_RGBA);
    assign advance    = !r_out_valid || i_out_ready;
    assign step       = r_in_valid && advance;
    assign o_in_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && o_in_ready) begin
            r_in_valid <= 1'b1;
        end else if (step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_byte  <= i_data_byte;
            r_in_first <= i_first;
        end
    end

    tga_rle_pkt u_pkt (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_first     (r_in_first),
        .i_data_byte (r_in_byte),
        .i_rle_mode  (r_rle_mode),
        .i_bpp4      (bpp4),
        .i_finished  (finished),
        .o_req       (req),
        .o_pixel     (pixel)
    );

    tga_rle_pos #(
        .DIM_W (DIM_W)
    ) u_pos (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (step),
        .i_first    (r_in_first),
        .i_width    (width),
        .i_height   (height),
        .i_req      (req),
        .o_finished (finished),
        .o_res      (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= res.emit;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && res.emit) begin
            r_out_pix <= pixel;
            r_out_res <= res;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_red          = r_out_pix.red;
    assign o_green        = r_out_pix.green;
    assign o_blue         = r_out_pix.blue;
    assign o_alpha        = r_out_pix.alpha;
    assign o_column       = r_out_res.column;
    assign o_row          = r_out_res.row;
    assign o_repeat_count = r_out_res.cnt;
    assign o_last         = r_out_res.last;

endmodule
`default_nettype wire

>>> dv/testbench.sv
// Self-checking testbench for the TGA run-length pixel decoder.
`timescale 1ns / 1ps
module testbench;
    import tga_rle_pkg::*;

    localparam int CLK_HALF       = 4;
    localparam int LONG_HOLD      = 400;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RANDOM_BYTES   = 700;

    typedef struct packed {
        logic [BYTE_W-1:0]    red;
        logic [BYTE_W-1:0]    green;
        logic [BYTE_W-1:0]    blue;
        logic [BYTE_W-1:0]    alpha;
        logic [POS_OUT_W-1:0] column;
        logic [POS_OUT_W-1:0] row;
        logic [CNT_W-1:0]     cnt;
        logic                 last;
    } t_pixel_result;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              first;
    } t_byte_item;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic [BYTE_W-1:0]    data_byte = '0;
    logic                 first_flag = 1'b0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [BYTE_W-1:0]    red, green, blue, alpha;
    logic [POS_OUT_W-1:0] column, row;
    logic [CNT_W-1:0]     repeat_count;
    logic                 last;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data = '0;

    tga_rle_pixel_decoder u_dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_ready     (in_ready),
        .i_data_byte    (data_byte),
        .i_first        (first_flag),
        .o_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .o_red          (red),
        .o_green        (green),
        .o_blue         (blue),
        .o_alpha        (alpha),
        .o_column       (column),
        .o_row          (row),
        .o_repeat_count (repeat_count),
        .o_last         (last),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data)
    );

    always #CLK_HALF clk = ~clk;

    // Shadow copy of the decoder: registers, packet state and write position.
    logic             cfg_mode = 1'b0;
    logic [2:0]       cfg_bpp = BPP_RGB;
    logic [CFG_W-1:0] cfg_w = 13'd1;
    logic [CFG_W-1:0] cfg_h = 13'd1;
    bit               hdr_due = 1'b1;
    bit               run_pkt = 1'b0;
    int unsigned      px_left = 0;
    int unsigned      byte_pos = 0;
    logic [BYTE_W-1:0] pix_bytes [4] = '{default: 8'h00};
    longint unsigned  pos_col = 0;
    longint unsigned  pos_row = 0;
    bit               img_done = 1'b0;

    t_byte_item    byte_q [$];
    t_pixel_result pixel_expect_q [$];

    int idle_pct = 15;
    int hold_requests = 0;
    int holds_served = 0;
    int stall_left = 0;
    int quiet_cycles = 0;
    int mismatches = 0;
    int bytes_accepted = 0;
    int results_checked = 0;
    int images_completed = 0;
    int stim_bytes = 0;
    int settings_seen = 0;

    function automatic longint unsigned eff_dim(input logic [CFG_W-1:0] v);
        if (v == 0) return 1;
        if (v > MAX_DIM_DEF) return MAX_DIM_DEF;
        return v;
    endfunction

    // Writes a pixel of up to cnt repeats at the current position.
    function automatic bit place_pixel(input longint unsigned cnt, output t_pixel_result res);
        longint unsigned w, h, remaining, total;
        w = eff_dim(cfg_w);
        h = eff_dim(cfg_h);
        res = '0;
        if (img_done) return 1'b0;
        if (pos_col >= w) begin
            pos_col = 0;
            pos_row++;
        end
        if (pos_row >= h) begin
            img_done = 1'b1;
            return 1'b0;
        end
        remaining = (h - pos_row) * w - pos_col;
        if (cnt > remaining) cnt = remaining;
        res.red    = pix_bytes[2];
        res.green  = pix_bytes[1];
        res.blue   = pix_bytes[0];
        res.alpha  = (cfg_bpp >= BPP_RGBA) ? pix_bytes[3] : 8'h00;
        res.column = POS_OUT_W'(pos_col);
        res.row    = POS_OUT_W'(h - 1 - pos_row);
        res.cnt    = CNT_W'(cnt);
        total   = pos_col + cnt;
        pos_row = pos_row + total / w;
        pos_col = total % w;
        if (pos_row >= h) img_done = 1'b1;
        res.last = img_done;
        return 1'b1;
    endfunction

    function automatic bit decode_byte(input logic [BYTE_W-1:0] b, input logic first_in,
                                       output t_pixel_result res);
        int unsigned bpp;
        bit got;
        bpp = (cfg_bpp >= BPP_RGBA) ? 4 : 3;
        res = '0;
        got = 1'b0;
        if (first_in) begin
            hdr_due  = 1'b1;
            run_pkt  = 1'b0;
            px_left  = 0;
            byte_pos = 0;
            pos_col  = 0;
            pos_row  = 0;
            img_done = 1'b0;
        end
        if (img_done) return 1'b0;
        if (cfg_mode && hdr_due) begin
            run_pkt  = b[HDR_RUN_BIT];
            px_left  = (b & HDR_LEN_MASK) + 1;
            hdr_due  = 1'b0;
            byte_pos = 0;
            return 1'b0;
        end
        pix_bytes[byte_pos % 4] = b;
        if (byte_pos + 1 < bpp) begin
            byte_pos = (byte_pos + 1) % 4;
            return 1'b0;
        end
        byte_pos = 0;
        if (!cfg_mode) begin
            got = place_pixel(1, res);
        end else if (run_pkt) begin
            got = place_pixel(px_left, res);
            px_left = 0;
            hdr_due = 1'b1;
        end else begin
            got = place_pixel(1, res);
            if (px_left > 0) px_left--;
            if (px_left == 0) hdr_due = 1'b1;
        end
        if (bpp == 3) pix_bytes[3] = 8'h00;
        return got;
    endfunction

    function automatic string fmt_pixel(input t_pixel_result p);
        return $sformatf("rgba=%02h%02h%02h%02h col=%0d row=%0d cnt=%0d last=%0b",
                         p.red, p.green, p.blue, p.alpha, p.column, p.row, p.cnt, p.last);
    endfunction

    // Sender: when the channel is free, offers the next queued byte unless a random idle draw holds it back.
    always @(posedge clk) begin : byte_driver
        t_byte_item    item;
        t_pixel_result res;
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && in_ready) begin
                bytes_accepted++;
                if (decode_byte(data_byte, first_flag, res)) pixel_expect_q.push_back(res);
            end
            if (!in_valid || in_ready) begin
                if (byte_q.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
                    item = byte_q.pop_front();
                    data_byte  <= item.data;
                    first_flag <= item.first;
                    in_valid   <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: random back-pressure plus long hold-offs on request.
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else if (stall_left > 0) begin
            out_ready  <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (holds_served != hold_requests) begin
            out_ready    <= 1'b0;
            holds_served <= holds_served + 1;
            stall_left   <= LONG_HOLD;
        end else begin
            out_ready <= ($urandom_range(0, 99) >= idle_pct);
        end
    end

    always @(posedge clk) begin : result_monitor
        t_pixel_result got, exp_res;
        if (rst_n && out_valid && out_ready) begin
            got = '{red: red, green: green, blue: blue, alpha: alpha, column: column,
                    row: row, cnt: repeat_count, last: last};
            if (pixel_expect_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("Unexpected result: %s", fmt_pixel(got));
            end else begin
                exp_res = pixel_expect_q.pop_front();
                results_checked++;
                if (exp_res.last) images_completed++;
                if (got !== exp_res) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("Mismatch on result %0d:", results_checked);
                        $display("  expected %s", fmt_pixel(exp_res));
                        $display("  actual   %s", fmt_pixel(got));
                    end
                end
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
                || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout: no item moved for %0d cycles, %0d results still due",
                     quiet_cycles, pixel_expect_q.size());
            $display("** tga_rle_pixel_decoder: FAILED **");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic write_reg(input t_cfg_reg idx, input logic [CFG_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_RLE_MODE: cfg_mode = val[0];
            CFG_BPP:      cfg_bpp  = val[2:0];
            CFG_WIDTH:    cfg_w    = val;
            CFG_HEIGHT:   cfg_h    = val;
            default: ;
        endcase
    endtask

    // Waits until every queued byte is in and every expected result is out,
    // then lets any byte that makes no result clear the pipeline.
    task automatic settle();
        do @(posedge clk); while (byte_q.size() != 0 || in_valid || pixel_expect_q.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic push_byte(input logic [BYTE_W-1:0] b, input logic f, input bit counted);
        byte_q.push_back('{data: b, first: f});
        if (counted) stim_bytes++;
    endtask

    task automatic push_pixel(input int bpp, input bit lead);
        for (int i = 0; i < bpp; i++) push_byte($urandom_range(0, 255), lead && i == 0, 1'b1);
    endtask

    function automatic logic [CFG_W-1:0] pick_dim();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 6);
        if (r < 80) return $urandom_range(7, 40);
        if (r < 85) return 0;
        if (r < 90) return MAX_DIM_DEF;
        if (r < 95) return MAX_DIM_DEF - 1;
        return $urandom_range(MAX_DIM_DEF + 1, 2 ** CFG_W - 1);
    endfunction

    task automatic random_setting();
        settings_seen++;
        if ($urandom_range(0, 1)) write_reg(CFG_RLE_MODE, $urandom_range(0, 1));
        if ($urandom_range(0, 1)) begin
            if ($urandom_range(0, 3) != 0) write_reg(CFG_BPP, $urandom_range(3, 4));
            else write_reg(CFG_BPP, $urandom_range(0, 7));
        end
        if ($urandom_range(0, 1)) write_reg(CFG_WIDTH, pick_dim());
        if ($urandom_range(0, 1)) write_reg(CFG_HEIGHT, pick_dim());
    endtask

    // Queues one image (or a continuation of the current one) in the current format.
    task automatic gen_image(input bit restart, input int max_pix);
        longint unsigned target, area, placed;
        int bpp, len, r;
        bit run, lead;
        logic [BYTE_W-1:0] hdr;
        bpp    = (cfg_bpp >= BPP_RGBA) ? 4 : 3;
        area   = eff_dim(cfg_w) * eff_dim(cfg_h);
        target = (!restart || area > max_pix) ? max_pix : area;
        placed = 0;
        lead   = restart;
        while (placed < target) begin
            // Now and then a packet is cut short; a later first byte restarts it.
            if ($urandom_range(0, 24) == 0) begin
                if (cfg_mode) push_byte($urandom_range(0, 255), lead, 1'b1);
                repeat ($urandom_range(0, bpp - 1)) push_byte($urandom_range(0, 255), 1'b0, 1'b1);
                return;
            end
            if (cfg_mode) begin
                run = $urandom_range(0, 1);
                r   = $urandom_range(0, 99);
                if (run && r < 20) begin
                    len = target - placed + $urandom_range(0, 3);
                    if (len > 128) len = 128;
                end else if (r < (run ? 30 : 3)) begin
                    len = $urandom_range(1, 128);
                end else begin
                    len = $urandom_range(1, run ? 8 : 4);
                end
                hdr = HDR_LEN_MASK & BYTE_W'(len - 1);
                hdr[HDR_RUN_BIT] = run;
                push_byte(hdr, lead, 1'b1);
                repeat (run ? 1 : len) push_pixel(bpp, 1'b0);
                placed += len;
            end else begin
                push_pixel(bpp, lead);
                placed++;
            end
            lead = 1'b0;
        end
        if (restart && target == area && $urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 6)) push_byte($urandom_range(0, 255), 1'b0, 1'b0);
        end
    endtask

    initial begin
        int phase;
        phase = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Reset format: one BGR pixel per image, trailing byte dropped.
        push_byte(8'h00, 1'b1, 1'b0);
        push_byte(8'hFF, 1'b0, 1'b0);
        push_byte(8'h5A, 1'b0, 1'b0);
        push_byte(8'h33, 1'b0, 1'b0);
        push_byte(8'hFF, 1'b1, 1'b0);
        push_byte(8'h00, 1'b0, 1'b0);
        push_byte(8'hC3, 1'b0, 1'b0);
        settle();

        // Oversized pixel size and width, zero height: a long run then a raw packet.
        write_reg(CFG_RLE_MODE, 13'd1);
        write_reg(CFG_BPP, 13'd7);
        write_reg(CFG_WIDTH, 13'h1FFF);
        write_reg(CFG_HEIGHT, 13'd0);
        push_byte(8'hFF, 1'b1, 1'b0);
        push_byte(8'h11, 1'b0, 1'b0);
        push_byte(8'h22, 1'b0, 1'b0);
        push_byte(8'h33, 1'b0, 1'b0);
        push_byte(8'h44, 1'b0, 1'b0);
        push_byte(8'h01, 1'b0, 1'b0);
        for (int i = 0; i < 8; i++) push_byte(8'hA0 + i, 1'b0, 1'b0);
        settle();

        // Undersized pixel size and a full-height column: output row at the top.
        write_reg(CFG_BPP, 13'd0);
        write_reg(CFG_WIDTH, 13'd1);
        write_reg(CFG_HEIGHT, MAX_DIM_DEF);
        push_byte(8'h80, 1'b1, 1'b0);
        push_byte(8'h0F, 1'b0, 1'b0);
        push_byte(8'hF0, 1'b0, 1'b0);
        push_byte(8'h96, 1'b0, 1'b0);
        settle();

        while (stim_bytes < RANDOM_BYTES) begin
            phase++;
            idle_pct = (phase >= 8 && phase < 14) ? 0 : 15;
            random_setting();
            if (phase == 4) begin
                hold_requests++;
                do gen_image(1'b1, 48); while (byte_q.size() < 24);
            end
            repeat ($urandom_range(1, 3)) begin
                gen_image(img_done || $urandom_range(0, 3) != 0, $urandom_range(1, 24));
                if ($urandom_range(0, 4) == 0) settle();
            end
            settle();
        end
        repeat (8) @(posedge clk);

        $display("Decoded %0d bytes into %0d checked results, %0d images completed,",
                 bytes_accepted, results_checked, images_completed);
        $display("across %0d register settings in raw and run-length modes.", settings_seen);
        if (mismatches == 0 && pixel_expect_q.size() == 0) begin
            $display("** tga_rle_pixel_decoder: PASSED **");
        end else begin
            $display("%0d mismatches, %0d results never arrived", mismatches,
                     pixel_expect_q.size());
            $display("** tga_rle_pixel_decoder: FAILED **");
        end
        $finish;
    end
endmodule

>>> files.f
sv/tga_rle_pkg.sv
sv/tga_rle_pkt.sv
sv/tga_rle_pos.sv
sv/tga_rle_pixel_decoder.sv
dv/testbench.sv
